// ----- src/tcce_pkg.sv -----
// Shared types and constants of the text console character engine.
// Holds the beat structs of both channels, request kinds and byte codes.
// Depends on nothing.
`default_nettype none

package tcce_pkg;

    localparam logic [1:0] KIND_PUT    = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_CURSOR = 2'd3;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_BS     = 8'h08;

    localparam logic [7:0] UTF8_CONT_MASK  = 8'hC0;
    localparam logic [7:0] UTF8_CONT       = 8'h80;
    localparam logic [7:0] UTF8_LEAD2_MASK = 8'hE0;
    localparam logic [7:0] UTF8_LEAD2      = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3_MASK = 8'hF0;
    localparam logic [7:0] UTF8_LEAD3      = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4_MASK = 8'hF8;
    localparam logic [7:0] UTF8_LEAD4      = 8'hF0;

    localparam logic [7:0] ATTR_RESET = 8'h07;

    localparam int         APB_AW   = 3;
    localparam logic [0:0] REG_ATTR = 1'b0;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LF    = 3'd1,
        OP_CR    = 3'd2,
        OP_TAB   = 3'd3,
        OP_BS    = 3'd4,
        OP_PRINT = 3'd5
    } byte_op_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        data_byte;
        logic [10:0]       cell_index;
        logic signed [7:0] req_row;
        logic signed [7:0] req_col;
    } in_beat_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_pos;
        logic [15:0] read_cell;
        logic        cell_written;
        logic [10:0] written_index;
        logic [15:0] written_value;
        logic        scrolled;
        logic        byte_dropped;
    } out_beat_t;

    typedef struct packed {
        logic       drop;
        logic [1:0] pending_next;
        byte_op_t   op;
        logic [7:0] ch;
    } filt_t;

endpackage

`default_nettype wire

// ----- src/tcce_utf8_filter.sv -----
// UTF-8 filter and control byte decode for the put byte request.
// Depends on tcce_pkg for byte codes and the filt_t result struct.
`default_nettype none

module tcce_utf8_filter (
    input  wire logic [7:0]   data_byte,
    input  wire logic [1:0]   pending,
    output tcce_pkg::filt_t   filt
);

    always_comb begin
        filt.drop         = 1'b0;
        filt.pending_next = 2'd0;
        filt.op           = tcce_pkg::OP_NONE;
        filt.ch           = data_byte;
        if (pending != 2'd0) begin
            filt.drop = 1'b1;
            if ((data_byte & tcce_pkg::UTF8_CONT_MASK) == tcce_pkg::UTF8_CONT) begin
                filt.pending_next = pending - 2'd1;
            end
        end else if (data_byte[7]) begin
            filt.op = tcce_pkg::OP_PRINT;
            filt.ch = tcce_pkg::CHAR_DOLLAR;
            if ((data_byte & tcce_pkg::UTF8_LEAD2_MASK) == tcce_pkg::UTF8_LEAD2) begin
                filt.pending_next = 2'd1;
            end else if ((data_byte & tcce_pkg::UTF8_LEAD3_MASK) == tcce_pkg::UTF8_LEAD3) begin
                filt.pending_next = 2'd2;
            end else if ((data_byte & tcce_pkg::UTF8_LEAD4_MASK) == tcce_pkg::UTF8_LEAD4) begin
                filt.pending_next = 2'd3;
            end else begin
                filt.drop = 1'b1;
                filt.op   = tcce_pkg::OP_NONE;
                filt.ch   = data_byte;
            end
        end else begin
            case (data_byte)
                tcce_pkg::CHAR_LF:  filt.op = tcce_pkg::OP_LF;
                tcce_pkg::CHAR_CR:  filt.op = tcce_pkg::OP_CR;
                tcce_pkg::CHAR_TAB: filt.op = tcce_pkg::OP_TAB;
                tcce_pkg::CHAR_BS:  filt.op = tcce_pkg::OP_BS;
                default:            filt.op = tcce_pkg::OP_PRINT;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/text_console_char_engine.sv -----
// Text console character engine: screen store, cursor and request sequencer.
// Depends on tcce_pkg and tcce_utf8_filter.
//
// Usage:
//   s_ channel carries one request beat (put byte, read cell, clear, set
//   cursor); m_ channel returns exactly one result beat per request. Both
//   use valid/ready. The APB port holds the attribute register at address 0.
//   The screen store is a ROWS*COLS by 16-bit memory with one write and one
//   registered read port; a single address counter walks it for clears,
//   scrolls and the initial fill.
// Timing:
//   put byte and set cursor go through EXEC and DONE, read cell through EXEC,
//   RDWAIT and DONE. Clear writes all cells in CLEAR; a put byte that scrolls
//   primes a read in PRIME, then moves all cells in SCROLL (one cell a cycle).
//   s_ready is high only while idle; the result beat goes valid as s_ready rises again.
// Reset:
//   after aresetn rises the store is filled with blank cells in attribute 7,
//   with s_ready low; APB writes are taken meanwhile.
// Stall:
//   a result waiting in the output register does not block the next accept;
//   a second result waits in the sequencer until the first beat is taken.
`default_nettype none

module text_console_char_engine #(
    parameter int ROWS     = 25,
    parameter int COLS     = 80,
    parameter int TAB_STOP = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tcce_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire tcce_pkg::in_beat_t            s_payload,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output tcce_pkg::out_beat_t                m_payload
);

    localparam int NCELLS = ROWS * COLS;
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);
    localparam int AW     = $clog2(NCELLS);
    localparam int TW     = $clog2(COLS + TAB_STOP);

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_PRIME  = 8'b0000_1000,
        S_SCROLL = 8'b0001_0000,
        S_CLEAR  = 8'b0010_0000,
        S_RDWAIT = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [1:0]          pend_reg, pend_next;
    logic [7:0]          attr_reg;
    logic                rd_hit_reg, rd_hit_next;
    tcce_pkg::in_beat_t  in_reg;
    tcce_pkg::out_beat_t res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    tcce_pkg::out_beat_t m_payload_reg, m_payload_next;

    logic [15:0]         screen_mem [NCELLS];
    logic [15:0]         mem_q_reg;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [15:0]         mem_wdata;

    tcce_pkg::filt_t     filt;
    logic [TW-1:0]       tab_tbl [COLS];
    logic [TW-1:0]       tab_t;
    logic [RW:0]         row_inc, row_x;
    logic [CW:0]         col_inc, col_x;
    logic [CW-1:0]       wcol;
    logic                put_wr, put_scroll;
    logic [31:0]         widx32, ci32, ahead32, pos32, row32, col32;
    logic [15:0]         put_wval, blank_cur;
    logic signed [8:0]   rq, cq;
    logic [RW-1:0]       clamp_row;
    logic [CW-1:0]       clamp_col;
    logic                ci_hit, load_out, apb_wr;
    tcce_pkg::out_beat_t out_beat;

    tcce_utf8_filter u_filt (
        .data_byte (in_reg.data_byte),
        .pending   (pend_reg),
        .filt      (filt)
    );

    for (genvar g = 0; g < COLS; g++) begin : g_tab
        assign tab_tbl[g] = TW'((g / TAB_STOP + 1) * TAB_STOP);
    end

    assign blank_cur = {attr_reg, tcce_pkg::CHAR_SPACE};
    assign tab_t     = tab_tbl[col_reg];
    assign row_inc   = {1'b0, row_reg} + (RW+1)'(1);
    assign col_inc   = {1'b0, col_reg} + (CW+1)'(1);
    assign wcol      = (filt.op == tcce_pkg::OP_BS) ? col_reg - CW'(1) : col_reg;
    assign widx32    = 32'(row_reg) * COLS + 32'(wcol);
    assign put_wval  = (filt.op == tcce_pkg::OP_BS) ? blank_cur : {attr_reg, filt.ch};
    assign ci32      = 32'(in_reg.cell_index);
    assign ci_hit    = ci32 < NCELLS;
    assign ahead32   = 32'(cnt_reg) + 32'(COLS) + 32'd1;
    assign rq        = {in_reg.req_row[7], in_reg.req_row};
    assign cq        = {in_reg.req_col[7], in_reg.req_col};

    // put byte: cursor movement, cell write and scroll decision
    always_comb begin
        row_x  = {1'b0, row_reg};
        col_x  = {1'b0, col_reg};
        put_wr = 1'b0;
        if (!filt.drop) begin
            case (filt.op)
                tcce_pkg::OP_LF: begin
                    col_x = '0;
                    row_x = row_inc;
                end
                tcce_pkg::OP_CR: begin
                    col_x = '0;
                end
                tcce_pkg::OP_TAB: begin
                    if (tab_t >= TW'(COLS)) begin
                        col_x = '0;
                        row_x = row_inc;
                    end else begin
                        col_x = (CW+1)'(tab_t);
                    end
                end
                tcce_pkg::OP_BS: begin
                    if (col_reg != '0) begin
                        col_x  = col_x - (CW+1)'(1);
                        put_wr = 1'b1;
                    end
                end
                tcce_pkg::OP_PRINT: begin
                    put_wr = 1'b1;
                    if (col_inc >= (CW+1)'(COLS)) begin
                        col_x = '0;
                        row_x = row_inc;
                    end else begin
                        col_x = col_inc;
                    end
                end
                default: begin
                end
            endcase
        end
        put_scroll = row_x >= (RW+1)'(ROWS);
        if (put_scroll) begin
            row_x = (RW+1)'(ROWS - 1);
        end
    end

    always_comb begin
        if (rq < 9'sd0) begin
            clamp_row = '0;
        end else if (rq >= $signed(9'(ROWS))) begin
            clamp_row = RW'(ROWS - 1);
        end else begin
            clamp_row = rq[RW-1:0];
        end
        if (cq < 9'sd0) begin
            clamp_col = '0;
        end else if (cq >= $signed(9'(COLS))) begin
            clamp_col = CW'(COLS - 1);
        end else begin
            clamp_col = cq[CW-1:0];
        end
    end

    // result beat: cursor fields from the committed cursor
    always_comb begin
        row32    = 32'(row_reg);
        col32    = 32'(col_reg);
        pos32    = row32 * COLS + col32;
        out_beat = res_reg;
        out_beat.cursor_row = row32[4:0];
        out_beat.cursor_col = col32[6:0];
        out_beat.cursor_pos = pos32[10:0];
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        pend_next   = pend_reg;
        rd_hit_next = rd_hit_reg;
        res_next    = res_reg;
        s_ready     = 1'b0;
        load_out    = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = cnt_reg;
        mem_raddr   = cnt_reg;
        mem_wdata   = blank_cur;
        case (state_reg)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = {tcce_pkg::ATTR_RESET, tcce_pkg::CHAR_SPACE};
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == AW'(NCELLS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_next = '0;
                case (in_reg.kind)
                    tcce_pkg::KIND_PUT: begin
                        row_next   = row_x[RW-1:0];
                        col_next   = col_x[CW-1:0];
                        pend_next  = filt.pending_next;
                        mem_we     = put_wr;
                        mem_waddr  = widx32[AW-1:0];
                        mem_wdata  = put_wval;
                        res_next.cell_written  = put_wr;
                        res_next.written_index = put_wr ? widx32[10:0] : 11'd0;
                        res_next.written_value = put_wr ? put_wval : 16'd0;
                        res_next.scrolled      = put_scroll;
                        res_next.byte_dropped  = filt.drop;
                        state_next = put_scroll ? S_PRIME : S_DONE;
                    end
                    tcce_pkg::KIND_READ: begin
                        rd_hit_next = ci_hit;
                        mem_re      = ci_hit;
                        mem_raddr   = ci32[AW-1:0];
                        state_next  = S_RDWAIT;
                    end
                    tcce_pkg::KIND_CLEAR: begin
                        row_next   = '0;
                        col_next   = '0;
                        cnt_next   = '0;
                        state_next = S_CLEAR;
                    end
                    default: begin
                        row_next   = clamp_row;
                        col_next   = clamp_col;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_PRIME: begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(COLS);
                cnt_next   = '0;
                state_next = S_SCROLL;
            end
            S_SCROLL: begin
                // move each cell up one row, blank the bottom row
                mem_we    = 1'b1;
                mem_wdata = (cnt_reg < AW'(NCELLS - COLS)) ? mem_q_reg : blank_cur;
                mem_re    = ahead32 < NCELLS;
                mem_raddr = ahead32[AW-1:0];
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == AW'(NCELLS - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_CLEAR: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(NCELLS - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_RDWAIT: begin
                res_next.read_cell = rd_hit_reg ? mem_q_reg : 16'd0;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        if (load_out) begin
            m_valid_next   = 1'b1;
            m_payload_next = out_beat;
        end
    end

    assign apb_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tcce_pkg::REG_ATTR) ? {24'd0, attr_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            cnt_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            pend_reg    <= 2'd0;
            attr_reg    <= tcce_pkg::ATTR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (apb_wr && paddr[2] == tcce_pkg::REG_ATTR) begin
                attr_reg <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
        res_reg       <= res_next;
        rd_hit_reg    <= rd_hit_next;
        m_payload_reg <= m_payload_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            mem_q_reg <= screen_mem[mem_raddr];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(row_reg) < ROWS) && (32'(col_reg) < COLS))
        else $error("cursor outside the screen");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_reg.scrolled) |-> (32'(row_reg) == ROWS - 1))
        else $error("scroll left cursor off the bottom row");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> !(res_reg.cell_written && res_reg.byte_dropped))
        else $error("dropped byte wrote a cell");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("screen write while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(state_reg == S_DONE))
        else $error("result beat loaded outside the done step");

endmodule

`default_nettype wire

// ----- bench/tb_text_console_char_engine.sv -----
// Self-checking bench for text_console_char_engine: a queue-fed request driver,
// a result monitor and a request-level shadow of the screen, cursor and UTF-8 filter.
// Depends on tcce_pkg and the engine RTL.
`default_nettype none

module tb_text_console_char_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS        = 25;
    localparam int COLS        = 80;
    localparam int TAB_STOP    = 8;
    localparam int NCELLS      = ROWS * COLS;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int APB_AW      = tcce_pkg::APB_AW;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    tcce_pkg::in_beat_t  s_payload = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    tcce_pkg::out_beat_t m_payload;

    tcce_pkg::in_beat_t  pending_reqs[$];
    tcce_pkg::out_beat_t expected_results[$];
    logic [15:0] shadow_cells[NCELLS];
    int          shadow_row;
    int          shadow_col;
    int          utf8_skip;
    logic [7:0]  shadow_attr;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          err_count = 0;
    int          cycle_count = 0;

    text_console_char_engine #(
        .ROWS(ROWS),
        .COLS(COLS),
        .TAB_STOP(TAB_STOP)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_payload(s_payload),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload(m_payload)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic flag_error(string what);
        $display("ERROR @%0t: %s", $time, what);
        err_count++;
    endtask

    function automatic void blank_screen();
        for (int i = 0; i < NCELLS; i++) begin
            shadow_cells[i] = {shadow_attr, tcce_pkg::CHAR_SPACE};
        end
    endfunction

    function automatic tcce_pkg::out_beat_t console_step(tcce_pkg::in_beat_t b);
        tcce_pkg::out_beat_t o;
        logic [7:0] ch;
        bit         act;
        int         widx;
        int         r;
        int         c;
        o = '0;
        case (b.kind)
            tcce_pkg::KIND_PUT: begin
                ch  = b.data_byte;
                act = 1'b1;
                if (utf8_skip > 0) begin
                    utf8_skip--;
                    if ((ch & tcce_pkg::UTF8_CONT_MASK) != tcce_pkg::UTF8_CONT) utf8_skip = 0;
                    o.byte_dropped = 1'b1;
                    act = 1'b0;
                end else if (ch[7]) begin
                    if ((ch & tcce_pkg::UTF8_LEAD2_MASK) == tcce_pkg::UTF8_LEAD2) begin
                        utf8_skip = 1;
                        ch = tcce_pkg::CHAR_DOLLAR;
                    end else if ((ch & tcce_pkg::UTF8_LEAD3_MASK) == tcce_pkg::UTF8_LEAD3) begin
                        utf8_skip = 2;
                        ch = tcce_pkg::CHAR_DOLLAR;
                    end else if ((ch & tcce_pkg::UTF8_LEAD4_MASK) == tcce_pkg::UTF8_LEAD4) begin
                        utf8_skip = 3;
                        ch = tcce_pkg::CHAR_DOLLAR;
                    end else begin
                        o.byte_dropped = 1'b1;
                        act = 1'b0;
                    end
                end
                if (act) begin
                    if (ch == tcce_pkg::CHAR_LF) begin
                        shadow_col = 0;
                        shadow_row++;
                    end else if (ch == tcce_pkg::CHAR_CR) begin
                        shadow_col = 0;
                    end else if (ch == tcce_pkg::CHAR_TAB) begin
                        shadow_col = (shadow_col / TAB_STOP + 1) * TAB_STOP;
                        if (shadow_col >= COLS) begin
                            shadow_col = 0;
                            shadow_row++;
                        end
                    end else if (ch == tcce_pkg::CHAR_BS) begin
                        if (shadow_col > 0) begin
                            shadow_col--;
                            widx = shadow_row * COLS + shadow_col;
                            shadow_cells[widx] = {shadow_attr, tcce_pkg::CHAR_SPACE};
                            o.cell_written  = 1'b1;
                            o.written_index = 11'(widx);
                            o.written_value = {shadow_attr, tcce_pkg::CHAR_SPACE};
                        end
                    end else begin
                        widx = shadow_row * COLS + shadow_col;
                        shadow_cells[widx] = {shadow_attr, ch};
                        o.cell_written  = 1'b1;
                        o.written_index = 11'(widx);
                        o.written_value = {shadow_attr, ch};
                        shadow_col++;
                        if (shadow_col >= COLS) begin
                            shadow_col = 0;
                            shadow_row++;
                        end
                    end
                    if (shadow_row >= ROWS) begin
                        for (int i = 0; i < NCELLS - COLS; i++) begin
                            shadow_cells[i] = shadow_cells[i + COLS];
                        end
                        for (int i = NCELLS - COLS; i < NCELLS; i++) begin
                            shadow_cells[i] = {shadow_attr, tcce_pkg::CHAR_SPACE};
                        end
                        shadow_row = ROWS - 1;
                        o.scrolled = 1'b1;
                    end
                end
            end
            tcce_pkg::KIND_READ: begin
                if (b.cell_index < NCELLS) o.read_cell = shadow_cells[b.cell_index];
            end
            tcce_pkg::KIND_CLEAR: begin
                blank_screen();
                shadow_row = 0;
                shadow_col = 0;
            end
            default: begin
                r = $signed(b.req_row);
                c = $signed(b.req_col);
                if (r < 0) r = 0;
                if (r >= ROWS) r = ROWS - 1;
                if (c < 0) c = 0;
                if (c >= COLS) c = COLS - 1;
                shadow_row = r;
                shadow_col = c;
            end
        endcase
        o.cursor_row = 5'(shadow_row);
        o.cursor_col = 7'(shadow_col);
        o.cursor_pos = 11'(shadow_row * COLS + shadow_col);
        return o;
    endfunction

    task automatic check_result(tcce_pkg::out_beat_t got, tcce_pkg::out_beat_t want);
        if (got.cursor_row !== want.cursor_row)
            flag_error($sformatf("cursor_row got %0d want %0d", got.cursor_row, want.cursor_row));
        if (got.cursor_col !== want.cursor_col)
            flag_error($sformatf("cursor_col got %0d want %0d", got.cursor_col, want.cursor_col));
        if (got.cursor_pos !== want.cursor_pos)
            flag_error($sformatf("cursor_pos got %0d want %0d", got.cursor_pos, want.cursor_pos));
        if (got.read_cell !== want.read_cell)
            flag_error($sformatf("read_cell got %h want %h", got.read_cell, want.read_cell));
        if (got.cell_written !== want.cell_written)
            flag_error($sformatf("cell_written got %b want %b",
                got.cell_written, want.cell_written));
        if (got.written_index !== want.written_index)
            flag_error($sformatf("written_index got %0d want %0d",
                got.written_index, want.written_index));
        if (got.written_value !== want.written_value)
            flag_error($sformatf("written_value got %h want %h",
                got.written_value, want.written_value));
        if (got.scrolled !== want.scrolled)
            flag_error($sformatf("scrolled got %b want %b", got.scrolled, want.scrolled));
        if (got.byte_dropped !== want.byte_dropped)
            flag_error($sformatf("byte_dropped got %b want %b",
                got.byte_dropped, want.byte_dropped));
    endtask

    function automatic tcce_pkg::in_beat_t random_beat(logic [1:0] k);
        tcce_pkg::in_beat_t b;
        b.kind       = k;
        b.data_byte  = 8'($urandom);
        b.cell_index = 11'($urandom_range(0, 2047));
        b.req_row    = 8'($urandom);
        b.req_col    = 8'($urandom);
        return b;
    endfunction

    function automatic void push_put(logic [7:0] ch);
        tcce_pkg::in_beat_t b;
        b = random_beat(tcce_pkg::KIND_PUT);
        b.data_byte = ch;
        pending_reqs.push_back(b);
    endfunction

    function automatic void push_read(logic [10:0] idx);
        tcce_pkg::in_beat_t b;
        b = random_beat(tcce_pkg::KIND_READ);
        b.cell_index = idx;
        pending_reqs.push_back(b);
    endfunction

    function automatic void push_cursor(logic [7:0] r, logic [7:0] c);
        tcce_pkg::in_beat_t b;
        b = random_beat(tcce_pkg::KIND_CURSOR);
        b.req_row = r;
        b.req_col = c;
        pending_reqs.push_back(b);
    endfunction

    function automatic logic [7:0] utf8_lead(int len);
        case (len)
            2:       return tcce_pkg::UTF8_LEAD2 | 8'($urandom_range(0, 31));
            3:       return tcce_pkg::UTF8_LEAD3 | 8'($urandom_range(0, 15));
            default: return tcce_pkg::UTF8_LEAD4 | 8'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic void gen_random(int n);
        int target;
        int pick;
        int len;
        target = pending_reqs.size() + n;
        while (pending_reqs.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                if ($urandom_range(0, 4) != 0) push_put(8'($urandom_range(8'h20, 8'h7E)));
                else push_put(8'($urandom_range(0, 127)));
            end else if (pick < 52) begin
                push_put(tcce_pkg::CHAR_LF);
            end else if (pick < 55) begin
                push_put(tcce_pkg::CHAR_CR);
            end else if (pick < 60) begin
                push_put(tcce_pkg::CHAR_TAB);
            end else if (pick < 66) begin
                push_put(tcce_pkg::CHAR_BS);
            end else if (pick < 76) begin
                len = $urandom_range(2, 4);
                push_put(utf8_lead(len));
                for (int i = 1; i < len; i++)
                    push_put(tcce_pkg::UTF8_CONT | 8'($urandom_range(0, 63)));
            end else if (pick < 79) begin
                len = $urandom_range(2, 4);
                push_put(utf8_lead(len));
                for (int i = $urandom_range(0, len - 2); i > 0; i--)
                    push_put(tcce_pkg::UTF8_CONT | 8'($urandom_range(0, 63)));
                push_put(8'($urandom));
            end else if (pick < 81) begin
                if ($urandom_range(0, 1) != 0)
                    push_put(tcce_pkg::UTF8_CONT | 8'($urandom_range(0, 63)));
                else push_put(8'hF8 | 8'($urandom_range(0, 7)));
            end else if (pick < 89) begin
                if ($urandom_range(0, 6) != 0) push_read(11'($urandom_range(0, NCELLS - 1)));
                else push_read(11'($urandom_range(NCELLS, 2047)));
            end else if (pick < 90) begin
                pending_reqs.push_back(random_beat(tcce_pkg::KIND_CLEAR));
            end else if (pick < 95) begin
                push_cursor(8'($urandom), 8'($urandom));
            end else begin
                push_cursor(8'($urandom_range(ROWS - 5, ROWS - 1)),
                            8'($urandom_range(0, COLS - 1)));
            end
        end
    endfunction

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == APB_AW'(4 * tcce_pkg::REG_ATTR)) shadow_attr = data[7:0];
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin
                send_idle = 34;
                recv_idle = 88;
            end
            1: begin
                send_idle = 88;
                recv_idle = 34;
            end
            default: begin
                send_idle = 0;
                recv_idle = 0;
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) expected_results.push_back(console_step(s_payload));
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    s_payload <= pending_reqs.pop_front();
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) flag_error("result beat with nothing expected");
                else check_result(m_payload, expected_results.pop_front());
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [7:0] attr_plan[6];
        attr_plan = '{8'h00, 8'hFF, 8'($urandom), 8'h4F, 8'($urandom), tcce_pkg::ATTR_RESET};
        shadow_attr = tcce_pkg::ATTR_RESET;
        shadow_row  = 0;
        shadow_col  = 0;
        utf8_skip   = 0;
        blank_screen();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        apb_write(APB_AW'(4 * tcce_pkg::REG_ATTR), {24'($urandom), 8'h1E});
        set_idling(0);
        push_put(8'h41);
        push_put(8'h00);
        push_put(tcce_pkg::CHAR_TAB);
        push_put(tcce_pkg::CHAR_BS);
        push_put(tcce_pkg::CHAR_CR);
        push_put(tcce_pkg::CHAR_BS);
        push_put(tcce_pkg::CHAR_LF);
        push_put(8'hC3);
        push_put(8'hA9);
        push_put(8'hE2);
        push_put(8'h82);
        push_put(8'hAC);
        push_put(8'hF0);
        push_put(8'h78);
        push_put(8'h80);
        push_put(8'hFF);
        push_read(11'd0);
        push_read(11'd2047);
        push_cursor(8'h80, 8'h80);
        push_cursor(8'h7F, 8'h7F);
        push_put(8'h5A);
        push_cursor(8'(ROWS - 1), 8'(COLS - 5));
        push_put(tcce_pkg::CHAR_TAB);
        pending_reqs.push_back(random_beat(tcce_pkg::KIND_CLEAR));
        push_cursor(8'(ROWS - 1), 8'h00);
        push_put(tcce_pkg::CHAR_LF);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            apb_write(APB_AW'(4 * tcce_pkg::REG_ATTR), {24'($urandom), attr_plan[ph]});
            set_idling(ph / 2);
            gen_random(215);
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (expected_results.size() != 0) flag_error("results still expected at end");
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
